// ===== rtl/epse_pkg.sv =====
`timescale 1ns / 1ps

package epse_pkg;

  // History of raw speed samples for the weighted moving average
  localparam int HISTORY_LEN = 8;
  localparam int HPW         = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
  localparam int HCW         = $clog2(HISTORY_LEN + 1);
  localparam int WTOT_MAX    = HISTORY_LEN * (HISTORY_LEN + 1) / 2;
  localparam int WTW         = $clog2(WTOT_MAX + 1);
  localparam int WSW         = 32 + WTW;

  // Shared restoring divider
  localparam int DIV_W  = 48;
  localparam int DIV_CW = $clog2(DIV_W);

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Alpha table: 1 - exp(-i*s), s = 8 / ALPHA_DEPTH, Q0.32
  localparam int ALPHA_DEPTH = 256;
  localparam int AIW         = $clog2(ALPHA_DEPTH);
  localparam int ALPHA_SHIFT = 35 - AIW;
  localparam logic [63:0] ONE_Q32    = 64'd1 << 32;
  localparam logic [63:0] ALPHA_STEP = (64'd1 << 35) / ALPHA_DEPTH;

  // Operation codes
  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NUM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MPS_GAIN  = 3'd4;

  typedef struct packed {
    logic [15:0] pulses;
    logic [31:0] tick_sum;
  } epse_item_t;

  typedef struct packed {
    logic [47:0] speed_num;
    logic [31:0] cutoff;
    logic [31:0] accel;
    logic [31:0] gain;
  } epse_cfg_t;

  typedef logic [31:0] alpha_tab_t [ALPHA_DEPTH];

  function automatic logic [63:0] taylor_mul(input logic [63:0] t);
    logic [63:0] p;
    p = (t * ALPHA_STEP) >> 32;
    return p;
  endfunction

  // exp(-s) from a series truncated after the 12th-order term, then powers rounded half up
  function automatic alpha_tab_t build_alpha();
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] e;
    alpha_tab_t  t;
    sum  = ONE_Q32;
    term = ONE_Q32;
    term = taylor_mul(term) / 64'd1;  sum = sum - term;
    term = taylor_mul(term) / 64'd2;  sum = sum + term;
    term = taylor_mul(term) / 64'd3;  sum = sum - term;
    term = taylor_mul(term) / 64'd4;  sum = sum + term;
    term = taylor_mul(term) / 64'd5;  sum = sum - term;
    term = taylor_mul(term) / 64'd6;  sum = sum + term;
    term = taylor_mul(term) / 64'd7;  sum = sum - term;
    term = taylor_mul(term) / 64'd8;  sum = sum + term;
    term = taylor_mul(term) / 64'd9;  sum = sum - term;
    term = taylor_mul(term) / 64'd10; sum = sum + term;
    term = taylor_mul(term) / 64'd11; sum = sum - term;
    term = taylor_mul(term) / 64'd12; sum = sum + term;
    e = ONE_Q32;
    for (int i = 0; i < ALPHA_DEPTH; i++) begin
      t[i] = 32'(ONE_Q32 - e);
      e    = (e * sum + (64'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam alpha_tab_t ALPHA_TAB = build_alpha();

endpackage

// ===== rtl/epse_front.sv =====
`timescale 1ns / 1ps

module epse_front import epse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [31:0] in_timestamp,
  input  logic [15:0] min_gap,
  input  logic        q_full,
  output logic        q_push,
  output epse_item_t  q_item
);

  logic [31:0] last_edge_r;
  logic [15:0] pend_pulses_r;
  logic [31:0] pend_sum_r;
  logic        xfer;
  logic [31:0] gap;
  logic [32:0] sum_ext;

  assign in_ready = !q_full;
  assign xfer     = in_valid && in_ready;
  assign gap      = in_timestamp - last_edge_r;
  assign sum_ext  = {1'b0, pend_sum_r} + {1'b0, gap};

  // Updates hand the pending count and sum to the back end
  assign q_push        = xfer && (in_operation == OP_UPDATE);
  assign q_item.pulses   = pend_pulses_r;
  assign q_item.tick_sum = pend_sum_r;

  // Edge qualification and pulse accumulation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r   <= '0;
      pend_pulses_r <= '0;
      pend_sum_r    <= '0;
    end else if (xfer) begin
      if (in_operation == OP_UPDATE) begin
        pend_pulses_r <= '0;
        pend_sum_r    <= '0;
      end else if (gap > {16'b0, min_gap}) begin
        last_edge_r <= in_timestamp;
        if (pend_pulses_r != 16'hFFFF) begin
          pend_pulses_r <= pend_pulses_r + 16'd1;
          pend_sum_r    <= sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
        end
      end
    end
  end

endmodule

// ===== rtl/epse_queue.sv =====
`timescale 1ns / 1ps

module epse_queue import epse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  epse_item_t push_item,
  output logic       full,
  output logic       valid,
  output epse_item_t item,
  input  logic       pop
);

  epse_item_t       mem_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r;
  logic [QPW-1:0]   rd_ptr_r;
  logic [QCW-1:0]   cnt_r;

  assign full  = (cnt_r == QCW'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  // Pointers wrap at the queue depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)
        rd_ptr_r <= (rd_ptr_r == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/epse_back.sv =====
`timescale 1ns / 1ps

module epse_back import epse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  epse_cfg_t   cfg,
  input  logic        q_valid,
  input  epse_item_t  q_item,
  output logic        q_pop,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] out_speed_dps,
  output logic [23:0] out_speed_mps,
  output logic [15:0] out_pulses_used
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_DIV   = 10'b00_0000_0010,
    S_HWR   = 10'b00_0000_0100,
    S_WACC  = 10'b00_0000_1000,
    S_MULX  = 10'b00_0001_0000,
    S_ALPHA = 10'b00_0010_0000,
    S_MAX   = 10'b00_0100_0000,
    S_DV    = 10'b00_1000_0000,
    S_MPS   = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } bstate_t;

  typedef enum logic [2:0] {
    PH_MEAN = 3'b001,
    PH_RAW  = 3'b010,
    PH_AVG  = 3'b100
  } dphase_t;

  bstate_t     state_r, state_nxt;
  dphase_t     phase_r;

  // Divider
  logic [DIV_W-1:0]  dvd_r;
  logic [31:0]       rem_r;
  logic [31:0]       dvs_r;
  logic [DIV_CW-1:0] dcnt_r;
  logic [32:0]       rem_sh;
  logic              div_ge;
  logic [31:0]       rem_new;
  logic [DIV_W-1:0]  quo_new;
  logic              div_last;

  // History and averaging
  logic [31:0]    hist_r [HISTORY_LEN];
  logic [HPW-1:0] wpos_r;
  logic [HPW-1:0] wpos_nxt;
  logic           full_r;
  logic           full_nxt;
  logic [HPW-1:0] rp_r;
  logic [HCW-1:0] w_r;
  logic [WSW-1:0] wsum_r;
  logic [WTW-1:0] wtot_r;
  logic [WSW-1:0] wsum_add;
  logic [WTW-1:0] wtot_add;

  // Speed path
  logic [15:0] pulses_r;
  logic [31:0] mean_r;
  logic [31:0] raw_r;
  logic [31:0] smooth_r;
  logic [31:0] cur_r;
  logic [31:0] alpha_r;
  logic        alpha_one_r;
  logic        up_r;
  logic [31:0] mag_r;
  logic [47:0] dvmax_r;
  logic [31:0] dv_full;
  logic [31:0] dv;

  // Shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod_r;

  logic        out_valid_r;
  logic        out_free;

  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  // One restoring step per cycle
  assign rem_sh   = {rem_r, dvd_r[DIV_W-1]};
  assign div_ge   = rem_sh >= {1'b0, dvs_r};
  assign rem_new  = div_ge ? 32'(rem_sh - {1'b0, dvs_r}) : rem_sh[31:0];
  assign quo_new  = {dvd_r[DIV_W-2:0], div_ge};
  assign div_last = (dcnt_r == DIV_CW'(DIV_W - 1));

  assign wpos_nxt = (wpos_r == HPW'(HISTORY_LEN - 1)) ? '0 : wpos_r + 1'b1;
  assign full_nxt = full_r || (wpos_nxt == '0);
  assign wsum_add = wsum_r + WSW'(hist_r[rp_r]) * WSW'(w_r);
  assign wtot_add = wtot_r + WTW'(w_r);

  assign dv_full = alpha_one_r ? mag_r : prod_r[63:32];
  assign dv      = ({16'b0, dv_full} > dvmax_r) ? dvmax_r[31:0] : dv_full;

  // Multiplier operand select
  always_comb begin
    case (state_r)
      S_MULX: begin
        mul_a = cfg.cutoff;
        mul_b = mean_r;
      end
      S_ALPHA: begin
        mul_a = cfg.accel;
        mul_b = mean_r;
      end
      S_MAX: begin
        mul_a = alpha_r;
        mul_b = mag_r;
      end
      default: begin
        mul_a = cur_r;
        mul_b = cfg.gain;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (q_valid) state_nxt = (q_item.pulses == '0) ? S_MPS : S_DIV;
      S_DIV: begin
        if (div_last) begin
          case (phase_r)
            PH_RAW:  state_nxt = S_HWR;
            PH_AVG:  state_nxt = S_MULX;
            default: state_nxt = S_DIV;
          endcase
        end
      end
      S_HWR:   state_nxt = S_WACC;
      S_WACC:  if (w_r == HCW'(1)) state_nxt = S_DIV;
      S_MULX:  state_nxt = S_ALPHA;
      S_ALPHA: state_nxt = S_MAX;
      S_MAX:   state_nxt = S_DV;
      S_DV:    state_nxt = S_MPS;
      S_MPS:   state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r      <= '0;
      full_r      <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_MEAN;
      for (int i = 0; i < HISTORY_LEN; i++) hist_r[i] <= '0;
    end else begin
      // Output register: load on a finished update, drop on transfer
      if ((state_r == S_FIN) && out_free) out_valid_r <= 1'b1;
      else if (out_ready)                 out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            pulses_r <= q_item.pulses;
            if (q_item.pulses == '0) begin
              cur_r <= '0;
            end else begin
              dvd_r   <= DIV_W'(q_item.tick_sum);
              dvs_r   <= {16'b0, q_item.pulses};
              rem_r   <= '0;
              dcnt_r  <= '0;
              phase_r <= PH_MEAN;
            end
          end
        end
        S_DIV: begin
          if (!div_last) begin
            dvd_r  <= quo_new;
            rem_r  <= rem_new;
            dcnt_r <= dcnt_r + 1'b1;
          end else begin
            case (phase_r)
              PH_MEAN: begin
                mean_r  <= (quo_new[31:0] == '0) ? 32'd1 : quo_new[31:0];
                dvd_r   <= cfg.speed_num;
                dvs_r   <= (quo_new[31:0] == '0) ? 32'd1 : quo_new[31:0];
                rem_r   <= '0;
                dcnt_r  <= '0;
                phase_r <= PH_RAW;
              end
              PH_RAW: begin
                raw_r <= (quo_new[47:32] != '0) ? 32'hFFFF_FFFF : quo_new[31:0];
              end
              default: begin
                smooth_r <= quo_new[31:0];
              end
            endcase
          end
        end
        S_HWR: begin
          // Store the new sample and start the walk at the newest entry
          hist_r[wpos_r] <= raw_r;
          wpos_r <= wpos_nxt;
          full_r <= full_nxt;
          rp_r   <= wpos_r;
          w_r    <= full_nxt ? HCW'(HISTORY_LEN) : HCW'(wpos_nxt);
          wsum_r <= '0;
          wtot_r <= '0;
        end
        S_WACC: begin
          wsum_r <= wsum_add;
          wtot_r <= wtot_add;
          w_r    <= w_r - 1'b1;
          rp_r   <= (rp_r == '0) ? HPW'(HISTORY_LEN - 1) : rp_r - 1'b1;
          if (w_r == HCW'(1)) begin
            dvd_r   <= DIV_W'(wsum_add);
            dvs_r   <= 32'(wtot_add);
            rem_r   <= '0;
            dcnt_r  <= '0;
            phase_r <= PH_AVG;
          end
        end
        S_ALPHA: begin
          // Filter coefficient from the registered cutoff * mean product
          alpha_one_r <= (prod_r[63:35] != '0);
          alpha_r     <= ALPHA_TAB[prod_r[34:ALPHA_SHIFT]];
          up_r        <= smooth_r >= cur_r;
          mag_r       <= (smooth_r >= cur_r) ? smooth_r - cur_r : cur_r - smooth_r;
        end
        S_MAX: begin
          dvmax_r <= prod_r[63:16];
        end
        S_DV: begin
          cur_r <= up_r ? cur_r + dv : cur_r - dv;
        end
        S_FIN: begin
          if (out_free) begin
            out_speed_dps   <= cur_r;
            out_speed_mps   <= (prod_r[63:56] != '0) ? 24'hFF_FFFF : prod_r[55:32];
            out_pulses_used <= pulses_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/encoder_period_speed_estimator_core.sv =====
`timescale 1ns / 1ps
// Encoder pulse-period speed estimator.
// Input channel (in_valid/in_ready): in_operation selects an edge event or a
// speed update; in_timestamp is the free-running timer value of an edge.
// Edges are qualified against min_gap and accumulated; they produce no
// result. Each update produces one result on the output channel
// (out_valid/out_ready): filtered speed in Q16.16 deg/s, Q8.16 m/s and the
// number of pulses consumed. Updates go through a two-entry queue to a
// sequential back end. An update makes three passes through the shared
// 48-step restoring divider (mean period, raw speed, weighted average),
// accumulates the weighted history one sample per cycle, then runs its
// setup, multiplies and output; an update with no pulses skips the divider
// and the history. Edges keep being taken while the back end works;
// in_ready drops only when the queue is full. When the receiver stalls,
// the result is held in the output register and the back end finishes the
// next update and waits for the register to free. Reset is synchronous:
// configuration returns to its defaults and the pending pulses, history and
// current speed clear to zero. The user must write configuration through
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.

module encoder_period_speed_estimator_core import epse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [31:0]          in_timestamp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_speed_dps,
  output logic [23:0]          out_speed_mps,
  output logic [15:0]          out_pulses_used,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0]          cfg_wdata
);

  logic [15:0] min_gap_r;
  epse_cfg_t   cfg_r;
  logic        q_push;
  epse_item_t  q_push_item;
  logic        q_full;
  logic        q_valid;
  epse_item_t  q_item;
  logic        q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r       <= 16'd100;
      cfg_r.speed_num <= 48'd32768000000;
      cfg_r.cutoff    <= 32'd269843;
      cfg_r.accel     <= 32'd4294967;
      cfg_r.gain      <= 32'd3748091;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_GAP:   min_gap_r       <= cfg_wdata[15:0];
        CFG_SPEED_NUM: cfg_r.speed_num <= cfg_wdata;
        CFG_CUTOFF:    cfg_r.cutoff    <= cfg_wdata[31:0];
        CFG_ACCEL:     cfg_r.accel     <= cfg_wdata[31:0];
        CFG_MPS_GAIN:  cfg_r.gain      <= cfg_wdata[31:0];
        default: begin
        end
      endcase
    end
  end

  epse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_timestamp (in_timestamp),
    .min_gap      (min_gap_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_push_item)
  );

  epse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .valid     (q_valid),
    .item      (q_item),
    .pop       (q_pop)
  );

  epse_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_speed_dps   (out_speed_dps),
    .out_speed_mps   (out_speed_mps),
    .out_pulses_used (out_pulses_used)
  );

endmodule

// ===== rtl/epse_checker.sv =====
`timescale 1ns / 1ps

module epse_checker import epse_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_speed_dps,
  input logic [23:0] out_speed_mps,
  input logic [15:0] out_pulses_used
);

  // No result is shown right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_speed_dps)
      && $stable(out_speed_mps) && $stable(out_pulses_used))
    else $error("stalled result changed");

  // An update without pulses stops the wheel
  a_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pulses_used == 16'd0) |-> out_speed_dps == 32'd0)
    else $error("nonzero speed without pulses");

  // Zero angular speed gives zero linear speed
  a_mps_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_speed_dps == 32'd0) |-> out_speed_mps == 24'd0)
    else $error("linear speed without angular speed");

endmodule

bind encoder_period_speed_estimator_core epse_checker u_epse_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_speed_dps   (out_speed_dps),
  .out_speed_mps   (out_speed_mps),
  .out_pulses_used (out_pulses_used)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import epse_pkg::*;

  typedef struct {
    logic [31:0] dps;
    logic [23:0] mps;
    logic [15:0] pulses;
  } speed_result_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [31:0] in_timestamp;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_speed_dps;
  logic [23:0] out_speed_mps;
  logic [15:0] out_pulses_used;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [47:0] cfg_wdata;

  encoder_period_speed_estimator_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_timestamp(in_timestamp),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_speed_dps(out_speed_dps), .out_speed_mps(out_speed_mps),
    .out_pulses_used(out_pulses_used),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state and configuration copy
  logic [31:0] alpha_lut [ALPHA_DEPTH];
  logic [15:0] m_min_gap;
  logic [47:0] m_speed_num;
  logic [31:0] m_cutoff;
  logic [31:0] m_accel;
  logic [31:0] m_gain;
  logic [31:0] m_last_edge;
  logic [15:0] m_pulses;
  logic [31:0] m_tick_sum;
  logic [31:0] m_hist [HISTORY_LEN];
  int          m_wpos;
  bit          m_full;
  logic [31:0] m_speed;

  speed_result_t pending_results[$];
  int  mismatches;
  int  idle_pct;
  int  stall_pct;
  int  quiet_cycles;
  logic [31:0] ts_now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // alpha = 1 - exp(-i*s), built from a truncated series for exp(-s)
  task automatic fill_alpha_lut();
    logic [63:0] series;
    logic [63:0] term;
    logic [63:0] e;
    series = 64'd1 << 32;
    term   = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * ALPHA_STEP) >> 32) / k;
      if (k % 2 == 1) series = series - term;
      else series = series + term;
    end
    e = 64'd1 << 32;
    for (int i = 0; i < ALPHA_DEPTH; i++) begin
      alpha_lut[i] = 32'((64'd1 << 32) - e);
      e = (e * series + (64'd1 << 31)) >> 32;
    end
  endtask

  task automatic reset_model();
    m_min_gap   = 16'd100;
    m_speed_num = 48'd32768000000;
    m_cutoff    = 32'd269843;
    m_accel     = 32'd4294967;
    m_gain      = 32'd3748091;
    m_last_edge = '0;
    m_pulses    = '0;
    m_tick_sum  = '0;
    for (int i = 0; i < HISTORY_LEN; i++) m_hist[i] = '0;
    m_wpos  = 0;
    m_full  = 0;
    m_speed = '0;
  endtask

  // Edge qualification and pulse/tick accumulation
  task automatic track_edge(input logic [31:0] ts);
    logic [31:0] gap;
    logic [32:0] acc;
    gap = ts - m_last_edge;
    if (gap > {16'd0, m_min_gap}) begin
      if (m_pulses != 16'hFFFF) begin
        acc = {1'b0, m_tick_sum} + {1'b0, gap};
        m_pulses++;
        m_tick_sum = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
      end
      m_last_edge = ts;
    end
  endtask

  // Speed update: mean period, raw speed, weighted average, low-pass, clamp
  task automatic compute_speed_update();
    speed_result_t r;
    logic [15:0] n;
    logic [63:0] tot, mean, q, x, idx, alpha, mag, dv, dvmax, mps, wsum, wtot, w;
    logic [31:0] raw, smooth;
    int cnt, pos;
    n = m_pulses;
    tot = {32'd0, m_tick_sum};
    m_pulses = '0;
    m_tick_sum = '0;
    if (n == 0) begin
      m_speed = '0;
      r.dps = '0; r.mps = '0; r.pulses = '0;
    end else begin
      mean = tot / n;
      if (mean == 0) mean = 1;
      q = {16'd0, m_speed_num} / mean;
      raw = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      m_hist[m_wpos] = raw;
      m_wpos = (m_wpos + 1) % HISTORY_LEN;
      if (m_wpos == 0) m_full = 1;
      cnt = m_full ? HISTORY_LEN : m_wpos;
      wsum = 0;
      wtot = 0;
      for (int i = 0; i < cnt; i++) begin
        w = cnt - i;
        pos = (m_wpos + HISTORY_LEN - 1 - i) % HISTORY_LEN;
        wsum += {32'd0, m_hist[pos]} * w;
        wtot += w;
      end
      smooth = 32'(wsum / wtot);
      x = {32'd0, m_cutoff} * mean;
      idx = x / ALPHA_STEP;
      alpha = (idx >= ALPHA_DEPTH) ? (64'd1 << 32) : {32'd0, alpha_lut[idx[AIW-1:0]]};
      mag = (smooth >= m_speed) ? {32'd0, smooth - m_speed} : {32'd0, m_speed - smooth};
      dv = (alpha * mag) >> 32;
      dvmax = ({32'd0, m_accel} * mean) >> 16;
      if (dv > dvmax) dv = dvmax;
      m_speed = (smooth >= m_speed) ? m_speed + dv[31:0] : m_speed - dv[31:0];
      mps = ({32'd0, m_speed} * m_gain) >> 32;
      if (mps > 64'hFF_FFFF) mps = 64'hFF_FFFF;
      r.dps = m_speed; r.mps = mps[23:0]; r.pulses = n;
    end
    pending_results.push_back(r);
  endtask

  // One input transfer; valid stays high across back-to-back items
  task automatic send_item(input logic op, input logic [31:0] ts);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_operation = op;
    in_timestamp = ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_EDGE) track_edge(ts);
    else compute_speed_update();
  endtask

  task automatic edge_after(input logic [31:0] gap);
    ts_now = ts_now + gap;
    send_item(OP_EDGE, ts_now);
  endtask

  task automatic request_update();
    send_item(OP_UPDATE, $urandom);
  endtask

  // Wait for all results, then let the back end settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_MIN_GAP:   m_min_gap   = val[15:0];
      CFG_SPEED_NUM: m_speed_num = val;
      CFG_CUTOFF:    m_cutoff    = val[31:0];
      CFG_ACCEL:     m_accel     = val[31:0];
      CFG_MPS_GAIN:  m_gain      = val[31:0];
      default: ;
    endcase
  endtask

  // Result checking against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result dps=%h", out_speed_dps);
      end else begin
        speed_result_t e;
        e = pending_results.pop_front();
        if (out_speed_dps !== e.dps || out_speed_mps !== e.mps ||
            out_pulses_used !== e.pulses) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp dps=%h mps=%h n=%0d got dps=%h mps=%h n=%0d",
                     e.dps, e.mps, e.pulses, out_speed_dps, out_speed_mps,
                     out_pulses_used);
        end
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed();
    request_update();                        // no pulses seen
    edge_after(32'd50);                      // too close: noise
    ts_now = 32'd100;
    send_item(OP_EDGE, ts_now);              // gap equal to threshold: rejected
    edge_after(32'd101);                     // first accepted edge
    edge_after(32'd1000);
    edge_after(32'd1200);
    request_update();
    ts_now = 32'hFFFF_FFF0;
    send_item(OP_EDGE, ts_now);
    edge_after(32'h0000_0200);               // timestamp wraps
    request_update();
    edge_after(32'hC000_0000);               // tick sum saturates,
    edge_after(32'hC000_0000);               // long period drives alpha to one
    request_update();
    edge_after(32'd500);
    edge_after(32'd500);
    request_update();
    ts_now = 32'hAAAA_AAAA;
    send_item(OP_EDGE, ts_now);
    ts_now = 32'h5555_5555;
    send_item(OP_EDGE, ts_now);
    request_update();
    request_update();
  endtask

  // Extreme settings, plus writes to unused indexes
  task automatic test_register_extremes();
    wait_idle();
    write_reg(CFG_MIN_GAP, 48'd0);
    write_reg(CFG_SPEED_NUM, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_CUTOFF, 48'hFFFF_FFFF);
    write_reg(CFG_ACCEL, 48'hFFFF_FFFF);
    write_reg(CFG_MPS_GAIN, 48'hFFFF_FFFF);
    write_reg(3'd5, 48'd7);
    write_reg(3'd7, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 6; i++) begin
      repeat ($urandom_range(1, 4)) edge_after($urandom_range(1, 3));
      request_update();
    end
    wait_idle();
    write_reg(CFG_MIN_GAP, 48'hFFFF);
    write_reg(CFG_SPEED_NUM, 48'd0);
    write_reg(CFG_CUTOFF, 48'd0);
    write_reg(CFG_ACCEL, 48'd0);
    write_reg(CFG_MPS_GAIN, 48'd0);
    for (int i = 0; i < 4; i++) begin
      edge_after(32'd65535);
      edge_after(32'd65536);
      request_update();
    end
  endtask

  // Random traffic: mostly edge bursts closed by an update
  task automatic test_random_phase(input int n_items, input int sidle, input int rstall);
    int sent;
    int burst;
    wait_idle();
    idle_pct = sidle;
    stall_pct = rstall;
    write_reg(CFG_MIN_GAP, 48'($urandom_range(0, 400)));
    write_reg(CFG_SPEED_NUM, {16'd0, $urandom} | 48'($urandom_range(0, 3)) << 40);
    write_reg(CFG_CUTOFF, 48'($urandom));
    write_reg(CFG_ACCEL, 48'($urandom));
    write_reg(CFG_MPS_GAIN, 48'($urandom));
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_item(1'($urandom_range(1)), $urandom);
        sent++;
      end else begin
        burst = $urandom_range(0, 8);
        for (int i = 0; i < burst; i++) begin
          case ($urandom_range(3))
            0: edge_after($urandom_range(0, 500));
            1: edge_after($urandom_range(200, 5000));
            2: edge_after($urandom_range(5000, 2000000));
            default: edge_after($urandom);
          endcase
        end
        request_update();
        sent += burst + 1;
      end
      if (sent > n_items / 2 && sent <= n_items / 2 + 9) wait_idle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_EDGE;
    in_timestamp = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    mismatches = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    ts_now = '0;
    fill_alpha_lut();
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_register_extremes();
    test_random_phase(300, 0, 0);
    test_random_phase(300, 54, 0);
    test_random_phase(300, 0, 54);
    test_random_phase(300, 22, 22);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
